### hdl/asrc_pkg.sv
// Shared types, constants and helpers for the anchor successor range counter.
// Used by the anchor store, the query sequencer, the top level and the checker.
package asrc_pkg;

	localparam int unsigned MAX_ANCHORS  = 8192;
	localparam int unsigned IDX_W        = $clog2(MAX_ANCHORS);
	localparam int unsigned CNT_W        = IDX_W + 1;
	localparam int unsigned SUM_W        = CNT_W + 1;
	localparam int unsigned SEG_W        = 32;
	localparam int unsigned POS_W        = 32;
	localparam int unsigned GAP_W        = 31;
	localparam int unsigned THR_W        = POS_W + 2;
	localparam int unsigned LEN_W        = 13;
	localparam int unsigned INDEX_W      = 13;
	localparam int unsigned DEFAULT_SPAN = 5000;
	localparam int unsigned TAIL_ZONE    = 16;
	localparam int unsigned GAP_RESET    = 5000;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [GAP_W-1:0] gap_t;
	typedef logic signed [THR_W-1:0] thr_t;

	typedef enum logic [1:0] {
		ACT_APPEND   = 2'd0,
		ACT_NEW_READ = 2'd1,
		ACT_QUERY    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		Q_IDLE,
		Q_RD_J,
		Q_RD_NEXT,
		Q_PROBE,
		Q_STEP
	} q_state_t;

	typedef struct packed {
		logic [SEG_W-1:0]        seg;
		logic signed [POS_W-1:0] pos;
	} anchor_t;

	typedef struct packed {
		logic en;
		idx_t addr;
	} rd_port_t;

	typedef struct packed {
		logic    en;
		idx_t    addr;
		anchor_t data;
	} wr_port_t;

	typedef struct packed {
		logic go;
		idx_t j;
		cnt_t n;
	} qry_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		len_t len;
	} qry_rsp_t;

	// Fixed probe offsets, walked in order during a range search.
	function automatic sum_t probe_off(input logic [2:0] k);
		sum_t off;
		case (k)
			3'd0:    off = sum_t'(0);
			3'd1:    off = sum_t'(16);
			3'd2:    off = sum_t'(512);
			3'd3:    off = sum_t'(1024);
			3'd4:    off = sum_t'(2048);
			3'd5:    off = sum_t'(3072);
			3'd6:    off = sum_t'(4096);
			default: off = sum_t'(5000);
		endcase
		return off;
	endfunction

endpackage

### hdl/asrc_store.sv
// Anchor store: one write port and one read port with registered read data.
// Depends on asrc_pkg for the entry and port types.
module asrc_store (
	input  logic                clk,
	input  asrc_pkg::wr_port_t  wr,
	input  asrc_pkg::rd_port_t  rd,
	output asrc_pkg::anchor_t   rd_data
);

	asrc_pkg::anchor_t mem_q [asrc_pkg::MAX_ANCHORS];
	asrc_pkg::anchor_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/asrc_query.sv
// Query sequencer: walks the anchor store through one read port to find a range end.
// Depends on asrc_pkg; drives the read port of asrc_store.
module asrc_query (
	input  logic               clk,
	input  logic               arst_n,
	input  asrc_pkg::qry_req_t req,
	input  asrc_pkg::gap_t     gap_limit,
	input  asrc_pkg::anchor_t  rd_data,
	output asrc_pkg::rd_port_t rd,
	output asrc_pkg::qry_rsp_t rsp
);

	asrc_pkg::q_state_t state_q, state_d;
	asrc_pkg::idx_t     j_q;
	asrc_pkg::cnt_t     n_q;
	logic [asrc_pkg::SEG_W-1:0] seg_j_q;
	asrc_pkg::thr_t     thr_q;
	logic [3:0]         ki_q;
	asrc_pkg::idx_t     tag_s1;
	logic               done_q;
	asrc_pkg::len_t     len_q;

	asrc_pkg::cnt_t j_ext, last_idx;
	asrc_pkg::sum_t span_end, paddr, seg_end;
	asrc_pkg::idx_t dflt_end, end_sel;
	asrc_pkg::thr_t pos_x;
	asrc_pkg::len_t step_len, fin_len;
	logic next_out, seg_eq, exceeds, tail, issue_ok;
	logic brk_seg, brk_gap, leave_probe, fin;

	assign j_ext    = asrc_pkg::cnt_t'(j_q);
	assign last_idx = n_q - asrc_pkg::cnt_t'(1);
	assign next_out = (j_ext + asrc_pkg::cnt_t'(1)) >= n_q;
	assign seg_eq   = rd_data.seg == seg_j_q;
	assign pos_x    = $signed({{(asrc_pkg::THR_W - asrc_pkg::POS_W){rd_data.pos[asrc_pkg::POS_W-1]}},
		rd_data.pos});
	// Gap test as one compare against the threshold taken when anchor j was read.
	assign exceeds  = pos_x > thr_q;
	assign tail     = (n_q - j_ext) <= asrc_pkg::cnt_t'(asrc_pkg::TAIL_ZONE);

	assign span_end = asrc_pkg::sum_t'(j_q) + asrc_pkg::sum_t'(asrc_pkg::DEFAULT_SPAN);
	assign dflt_end = (span_end > asrc_pkg::sum_t'(last_idx)) ? asrc_pkg::idx_t'(last_idx)
		: asrc_pkg::idx_t'(span_end);

	assign paddr    = asrc_pkg::sum_t'(j_q) + asrc_pkg::probe_off(ki_q[2:0]);
	assign issue_ok = !ki_q[3] && (paddr < asrc_pkg::sum_t'(n_q));
	// The response in hand belongs to probe ki_q-1; its predecessor is ki_q-2.
	assign seg_end  = asrc_pkg::sum_t'(j_q) + asrc_pkg::probe_off(ki_q[2:0] - 3'd2);

	assign brk_seg     = !seg_eq;
	assign brk_gap     = seg_eq && exceeds;
	assign leave_probe = brk_seg || brk_gap || !issue_ok;
	assign end_sel     = brk_seg ? asrc_pkg::idx_t'(seg_end) : (brk_gap ? tag_s1 : dflt_end);
	assign step_len    = asrc_pkg::len_t'(tag_s1 - j_q) + asrc_pkg::len_t'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			asrc_pkg::Q_IDLE: begin
				if (req.go) state_d = asrc_pkg::Q_RD_J;
			end
			asrc_pkg::Q_RD_J: begin
				state_d = next_out ? asrc_pkg::Q_IDLE : asrc_pkg::Q_RD_NEXT;
			end
			asrc_pkg::Q_RD_NEXT: begin
				if (!seg_eq) state_d = asrc_pkg::Q_IDLE;
				else if (tail) state_d = asrc_pkg::Q_STEP;
				else state_d = asrc_pkg::Q_PROBE;
			end
			asrc_pkg::Q_PROBE: begin
				if (leave_probe) state_d = asrc_pkg::Q_STEP;
			end
			asrc_pkg::Q_STEP: begin
				if (!exceeds) state_d = asrc_pkg::Q_IDLE;
			end
			default: state_d = asrc_pkg::Q_IDLE;
		endcase
	end

	always_comb begin
		rd.en   = 1'b0;
		rd.addr = j_q;
		fin     = 1'b0;
		fin_len = asrc_pkg::len_t'(1);
		unique case (state_q)
			asrc_pkg::Q_IDLE: begin
				rd.en   = req.go;
				rd.addr = req.j;
			end
			asrc_pkg::Q_RD_J: begin
				if (next_out) begin
					fin = 1'b1;
				end else begin
					rd.en   = 1'b1;
					rd.addr = asrc_pkg::idx_t'(j_ext + asrc_pkg::cnt_t'(1));
				end
			end
			asrc_pkg::Q_RD_NEXT: begin
				if (!seg_eq) begin
					fin = 1'b1;
				end else begin
					rd.en   = 1'b1;
					rd.addr = tail ? asrc_pkg::idx_t'(last_idx) : asrc_pkg::idx_t'(paddr);
				end
			end
			asrc_pkg::Q_PROBE: begin
				rd.en   = 1'b1;
				rd.addr = leave_probe ? end_sel : asrc_pkg::idx_t'(paddr);
			end
			asrc_pkg::Q_STEP: begin
				if (!exceeds) begin
					fin     = 1'b1;
					fin_len = step_len;
				end else begin
					rd.en   = 1'b1;
					rd.addr = (tag_s1 == j_q) ? j_q : tag_s1 - asrc_pkg::idx_t'(1);
				end
			end
			default: begin
				rd.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asrc_pkg::Q_IDLE;
			done_q  <= 1'b0;
			ki_q    <= 4'd1;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == asrc_pkg::Q_IDLE) begin
				ki_q <= 4'd1;
			end else if (state_q == asrc_pkg::Q_RD_NEXT ||
				(state_q == asrc_pkg::Q_PROBE && !leave_probe)) begin
				ki_q <= ki_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == asrc_pkg::Q_IDLE && req.go) begin
			j_q <= req.j;
			n_q <= req.n;
		end
		if (state_q == asrc_pkg::Q_RD_J) begin
			seg_j_q <= rd_data.seg;
			thr_q   <= $signed({{(asrc_pkg::THR_W - asrc_pkg::POS_W){rd_data.pos[asrc_pkg::POS_W-1]}},
				rd_data.pos}) + $signed({{(asrc_pkg::THR_W - asrc_pkg::GAP_W){1'b0}}, gap_limit});
		end
		if (rd.en) begin
			tag_s1 <= rd.addr;
		end
		if (fin) begin
			len_q <= fin_len;
		end
	end

	assign rsp.busy = state_q != asrc_pkg::Q_IDLE;
	assign rsp.done = done_q;
	assign rsp.len  = len_q;

endmodule

### hdl/anchor_successor_range_counter_top.sv
// Top level of the anchor successor range counter: command decode, anchor count,
// gap limit register. Depends on asrc_pkg, asrc_store and asrc_query.
//
//   Channel   Handshake              Beat contents
//   command   start / busy           action, segment_id, ref_pos, anchor_index
//   result    done (one-cycle strobe) successor_count, status
//   config    cfg_valid / cfg_ready  cfg_data (gap limit)
//
// Appends, new-read commands, unused codes and out-of-range queries need no
// query: the command beat is taken and its result shows on the next cycle.
// A range query reads the queried anchor and answers if it is the last one;
// else it reads the next anchor and answers if that lies in another segment;
// else it probes at the fixed offsets (one to seven probes, none within
// sixteen anchors of the end) and then steps the end position down until it
// is within the gap limit, each read going through the single read port of
// the anchor store. Busy is high while a query works; a new command is taken
// in the cycle its result strobe is shown. Reset clears the anchor count and
// sets the gap limit to 5000; the store contents are not cleared. The
// receiver cannot stall results, and cfg_ready is always high.
module anchor_successor_range_counter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          action,
	input  logic [asrc_pkg::SEG_W-1:0]          segment_id,
	input  logic signed [asrc_pkg::POS_W-1:0]   ref_pos,
	input  logic [asrc_pkg::INDEX_W-1:0]        anchor_index,
	output logic                                done,
	output logic [asrc_pkg::LEN_W-1:0]          successor_count,
	output logic [1:0]                          status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [asrc_pkg::GAP_W-1:0]          cfg_data
);

	asrc_pkg::gap_t     gap_limit_q;
	asrc_pkg::cnt_t     anchor_count_q;
	logic               imm_v_q;
	asrc_pkg::status_t  imm_st_q;

	asrc_pkg::wr_port_t wr;
	asrc_pkg::rd_port_t rd;
	asrc_pkg::anchor_t  rd_data;
	asrc_pkg::qry_req_t req;
	asrc_pkg::qry_rsp_t rsp;

	logic              accept, full, in_range, imm_v_d;
	asrc_pkg::status_t imm_st_d;

	// The configuration register can always take a write.
	assign cfg_ready = 1'b1;

	assign busy     = rsp.busy;
	assign accept   = start && !busy;
	assign full     = anchor_count_q == asrc_pkg::cnt_t'(asrc_pkg::MAX_ANCHORS);
	assign in_range = asrc_pkg::cnt_t'(anchor_index) < anchor_count_q;

	// Decode the command beat into a store write, a query launch or an
	// immediate result.
	always_comb begin
		imm_v_d  = 1'b0;
		imm_st_d = asrc_pkg::ST_OK;
		wr.en    = 1'b0;
		wr.addr  = anchor_count_q[asrc_pkg::IDX_W-1:0];
		wr.data  = '{seg: segment_id, pos: ref_pos};
		req.go   = 1'b0;
		req.j    = asrc_pkg::idx_t'(anchor_index);
		req.n    = anchor_count_q;
		if (accept) begin
			unique case (action)
				asrc_pkg::ACT_APPEND: begin
					imm_v_d  = 1'b1;
					wr.en    = !full;
					imm_st_d = full ? asrc_pkg::ST_FULL : asrc_pkg::ST_OK;
				end
				asrc_pkg::ACT_QUERY: begin
					req.go = in_range;
					if (!in_range) begin
						imm_v_d  = 1'b1;
						imm_st_d = asrc_pkg::ST_BAD_INDEX;
					end
				end
				default: begin
					imm_v_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q    <= asrc_pkg::gap_t'(asrc_pkg::GAP_RESET);
			anchor_count_q <= '0;
			imm_v_q        <= 1'b0;
		end else begin
			imm_v_q <= imm_v_d;
			if (cfg_valid && cfg_ready) begin
				gap_limit_q <= cfg_data;
			end
			if (wr.en) begin
				anchor_count_q <= anchor_count_q + asrc_pkg::cnt_t'(1);
			end else if (accept && action == asrc_pkg::ACT_NEW_READ) begin
				anchor_count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (imm_v_d) begin
			imm_st_q <= imm_st_d;
		end
	end

	asrc_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	asrc_query u_query (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.gap_limit (gap_limit_q),
		.rd_data   (rd_data),
		.rd        (rd),
		.rsp       (rsp)
	);

	// Query results and immediate results never fall in the same cycle, since
	// the query sequencer holds busy until its own strobe.
	assign done            = imm_v_q || rsp.done;
	assign successor_count = rsp.done ? rsp.len : '0;
	assign status          = rsp.done ? asrc_pkg::ST_OK : imm_st_q;

endmodule

### hdl/asrc_chk.sv
// Port-level checker for the anchor successor range counter, bound to the top level.
// Depends on asrc_pkg for the action and status codes.
module asrc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  action,
	input logic        done,
	input logic [12:0] successor_count,
	input logic [1:0]  status
);

	// A result strobe never coincides with a running query.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// Commands other than queries answer on the next cycle with a zero count.
	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != asrc_pkg::ACT_QUERY) |=> (done && successor_count == '0))
		else $error("non-query command without its result");

	// A query either fails at once on its index or starts working.
	a_query_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == asrc_pkg::ACT_QUERY) |=>
		((done && status == asrc_pkg::ST_BAD_INDEX) || (busy && !done)))
		else $error("query neither rejected nor started");

	// Busy only rises after a query beat.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && action == asrc_pkg::ACT_QUERY))
		else $error("busy without a query");

	// A nonzero range length only comes with an ok status.
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && successor_count != '0) |-> status == asrc_pkg::ST_OK)
		else $error("range length with an error status");

endmodule

bind anchor_successor_range_counter_top asrc_chk u_asrc_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.action          (action),
	.done            (done),
	.successor_count (successor_count),
	.status          (status)
);

### tb/tb.sv
// Self-checking testbench for anchor_successor_range_counter_top.
// Depends on asrc_pkg and the RTL under hdl. A local predictor of the anchor store and the
// range search computes each reply, and a checker compares it with the strobed result.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import asrc_pkg::*;

	// The command port carries a fourth action code that the block ignores.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int unsigned RANDOM_ITEMS = 1650;
	localparam gap_t GAP_MAX = '1;
	localparam int unsigned PROBE_OFFS [8] = '{0, 16, 512, 1024, 2048, 3072, 4096, 5000};

	// One expected reply: the range length and the status code.
	typedef struct packed {
		len_t    count;
		status_t code;
	} reply_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [1:0]              action = ACT_APPEND;
	logic [SEG_W-1:0]        segment_id = '0;
	logic signed [POS_W-1:0] ref_pos = '0;
	logic [INDEX_W-1:0]      anchor_index = '0;
	logic                    done;
	len_t                    successor_count;
	logic [1:0]              status;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	gap_t                    cfg_data = '0;

	// Predictor state: the anchors of the current read, their count and the gap limit.
	logic [SEG_W-1:0]        seg_mem [MAX_ANCHORS];
	logic signed [POS_W-1:0] pos_mem [MAX_ANCHORS];
	int unsigned             n_anchors = 0;
	gap_t                    gap_limit = gap_t'(GAP_RESET);

	reply_t                  pending_replies [$];
	int unsigned             errors = 0;
	int unsigned             items_sent = 0;
	int unsigned             send_idle_pct = 0;

	anchor_successor_range_counter_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.segment_id      (segment_id),
		.ref_pos         (ref_pos),
		.anchor_index    (anchor_index),
		.done            (done),
		.successor_count (successor_count),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A hung handshake or a lost result ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	// True when anchor a sits further above anchor b than the gap limit allows. The
	// difference is taken in 64 bits so that it never wraps.
	function automatic bit gap_over(int unsigned a, int unsigned b);
		longint diff;
		diff = longint'(pos_mem[a]) - longint'(pos_mem[b]);
		return diff > longint'(gap_limit);
	endfunction

	// Successor range length of anchor j in a read of n anchors.
	function automatic len_t span_length(int unsigned j, int unsigned n);
		int unsigned last;
		int unsigned probe;
		bit          stop;
		if (j + 1 >= n || seg_mem[j + 1] != seg_mem[j])
			return len_t'(1);
		stop = 1'b0;
		last = j + DEFAULT_SPAN;
		if (last > n - 1)
			last = n - 1;
		// Walk the fixed probes. A segment change ends the range at the previous probe,
		// a position jump ends it at the probe itself.
		for (int k = 0; k < 8 && !stop; k++) begin
			probe = j + PROBE_OFFS[k];
			if (probe < n) begin
				if (seg_mem[probe] == seg_mem[j]) begin
					if (gap_over(probe, j)) begin
						last = probe;
						stop = 1'b1;
					end
				end else begin
					last = (k > 0) ? j + PROBE_OFFS[k - 1] : j;
					stop = 1'b1;
				end
			end
			// Close to the end of the read the range always reaches the last anchor.
			if (!stop && n - j <= TAIL_ZONE)
				last = n - 1;
		end
		while (last > j && gap_over(last, j))
			last--;
		return len_t'(last - j + 1);
	endfunction

	// Applies one accepted command to the predictor and returns the reply it causes.
	function automatic reply_t compute_reply(logic [1:0] act, logic [SEG_W-1:0] seg,
			logic [POS_W-1:0] pos, logic [INDEX_W-1:0] idx);
		reply_t r;
		r.count = '0;
		r.code = ST_OK;
		case (act)
			ACT_APPEND: begin
				if (n_anchors < MAX_ANCHORS) begin
					seg_mem[n_anchors] = seg;
					pos_mem[n_anchors] = pos;
					n_anchors++;
				end else begin
					r.code = ST_FULL;
				end
			end
			ACT_NEW_READ: begin
				n_anchors = 0;
			end
			ACT_QUERY: begin
				if (idx < n_anchors)
					r.count = span_length(idx, n_anchors);
				else
					r.code = ST_BAD_INDEX;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
		errors++;
		if (errors <= 30)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endfunction

	// Sends one command beat. The sender may idle first; start is left high after the beat
	// so that a following beat can go out back to back.
	task automatic send_item(input logic [1:0] act, input logic [SEG_W-1:0] seg,
			input logic [POS_W-1:0] pos, input int unsigned idx);
		logic [INDEX_W-1:0] idx_bits;
		idx_bits = idx[INDEX_W-1:0];
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		segment_id <= seg;
		ref_pos <= pos;
		anchor_index <= idx_bits;
		do @(posedge clk); while (busy);
		pending_replies.push_back(compute_reply(act, seg, pos, idx_bits));
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	// Holds the sender off until every expected reply has been seen.
	task automatic wait_until_idle();
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// The gap limit is written only while no command is in flight.
	task automatic write_gap(input gap_t value);
		wait_until_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gap_limit = value;
	endtask

	// Every strobed result is matched against the oldest expected reply.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 30)
					$display("%0t: unexpected result, count %0d status %0d", $time,
						successor_count, status);
			end else begin
				want = pending_replies.pop_front();
				if (successor_count !== want.count)
					flag_mismatch("successor_count", want.count, successor_count);
				if (status !== want.code)
					flag_mismatch("status", want.code, status);
			end
		end
	end

	// Out-of-range queries on an empty store, the unused action code and a new read with
	// nothing stored.
	task automatic test_empty_store();
		send_item(ACT_QUERY, '0, '0, 0);
		send_item(ACT_UNUSED, '1, '1, MAX_ANCHORS - 1);
		send_item(ACT_NEW_READ, '0, '0, 0);
		send_item(ACT_QUERY, '0, '0, 0);
	endtask

	// Short read with extreme positions and segment ids, checked under the reset gap
	// limit, a zero limit and the largest limit.
	task automatic test_extremes();
		send_item(ACT_NEW_READ, '0, '0, 0);
		// 5000 apart is still inside the reset limit, 5001 apart is not.
		send_item(ACT_APPEND, '0, 32'sd0, 0);
		send_item(ACT_APPEND, '0, 32'sd5000, 0);
		send_item(ACT_APPEND, '0, 32'sd5001, 0);
		send_item(ACT_QUERY, '0, '0, 0);
		send_item(ACT_QUERY, '0, '0, 2);
		send_item(ACT_APPEND, '1, 32'h7FFF_FFFF, 0);
		send_item(ACT_APPEND, '1, 32'h8000_0000, 0);
		send_item(ACT_QUERY, '0, '0, 3);
		send_item(ACT_QUERY, '0, '0, 2);
		send_item(ACT_QUERY, '0, '0, 5);
		send_item(ACT_QUERY, '0, '0, MAX_ANCHORS - 1);
		write_gap('0);
		send_item(ACT_QUERY, '0, '0, 0);
		send_item(ACT_QUERY, '0, '0, 1);
		// The widest span of two positions exceeds even the largest limit.
		write_gap(GAP_MAX);
		send_item(ACT_NEW_READ, '0, '0, 0);
		send_item(ACT_APPEND, 32'd5, 32'h8000_0000, 0);
		send_item(ACT_APPEND, 32'd5, 32'h7FFF_FFFF, 0);
		send_item(ACT_QUERY, '0, '0, 0);
		send_item(ACT_UNUSED, '1, '1, MAX_ANCHORS - 1);
		write_gap(gap_t'(GAP_RESET));
	endtask

	// Fills the whole store with segment runs, many of them long, so that every probe offset is reached,
	// appends once more into the full store, then queries it under several limits.
	task automatic test_full_store();
		logic [SEG_W-1:0] seg_now;
		logic [POS_W-1:0] pos_now;
		int unsigned      run_left;
		gap_t             limits [5];
		send_idle_pct = 0;
		limits = '{gap_t'(GAP_RESET), '0, gap_t'(400), gap_t'(20000), GAP_MAX};
		run_left = 0;
		pos_now = $urandom;
		seg_now = $urandom;
		send_item(ACT_NEW_READ, '0, '0, 0);
		for (int i = 0; i < MAX_ANCHORS; i++) begin
			if (run_left == 0) begin
				seg_now = $urandom;
				case ($urandom_range(2))
					0: run_left = $urandom_range(1, 24);
					1: run_left = $urandom_range(400, 2500);
					default: run_left = $urandom_range(4000, 6000);
				endcase
			end
			run_left--;
			if ($urandom_range(9) == 0)
				pos_now = pos_now + $urandom_range(100, 3000);
			else
				pos_now = pos_now + $urandom_range(6);
			send_item(ACT_APPEND, seg_now, pos_now, $urandom);
		end
		send_item(ACT_APPEND, $urandom, $urandom, $urandom);
		foreach (limits[g]) begin
			write_gap(limits[g]);
			send_item(ACT_QUERY, '0, '0, 0);
			send_item(ACT_QUERY, '0, '0, MAX_ANCHORS - 1);
			send_item(ACT_QUERY, '0, '0, MAX_ANCHORS - TAIL_ZONE);
			send_item(ACT_QUERY, '0, '0, MAX_ANCHORS - TAIL_ZONE - 1);
			send_item(ACT_QUERY, '0, '0, MAX_ANCHORS - DEFAULT_SPAN - 1);
			for (int q = 0; q < 10; q++)
				send_item(ACT_QUERY, '0, '0, $urandom_range(MAX_ANCHORS - 1));
		end
		send_item(ACT_NEW_READ, '0, '0, 0);
	endtask

	// Random reads: mostly a new read, a run of appends with a few segment ids and
	// position steps scaled to the gap limit, then queries. Some noise is mixed in.
	task automatic test_random_reads(input int unsigned item_goal, input int unsigned idle_pct,
			input gap_t limit);
		logic [SEG_W-1:0] palette [3];
		logic [SEG_W-1:0] seg_now;
		logic [POS_W-1:0] pos_now;
		int unsigned      stop_at;
		int unsigned      read_len;
		int unsigned      step_cap;
		int unsigned      seg_pct;
		int unsigned      n_queries;
		int unsigned      tail_span;
		int unsigned      idx;
		int unsigned      r;
		write_gap(limit);
		send_idle_pct = idle_pct;
		stop_at = items_sent + item_goal;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 8) begin
				send_item(2'($urandom_range(3)), $urandom, $urandom, $urandom_range(8191));
			end else begin
				if ($urandom_range(99) < 85)
					send_item(ACT_NEW_READ, $urandom, $urandom, $urandom);
				foreach (palette[p])
					palette[p] = $urandom;
				seg_now = palette[0];
				pos_now = $urandom;
				r = $urandom_range(99);
				if (r < 80)
					read_len = $urandom_range(1, 20);
				else if (r < 96)
					read_len = $urandom_range(17, 60);
				else
					read_len = $urandom_range(513, 700);
				// Long reads keep one segment and take fine steps so that the far
				// probes are reached.
				if (read_len > 100) begin
					step_cap = int'(gap_limit) / 1024 + 1;
					seg_pct = 0;
				end else begin
					step_cap = int'(gap_limit) / 6 + 1;
					seg_pct = 12;
				end
				for (int i = 0; i < read_len; i++) begin
					if ($urandom_range(99) < seg_pct)
						seg_now = palette[$urandom_range(2)];
					r = $urandom_range(99);
					if (r < 70)
						pos_now = pos_now + $urandom_range(step_cap);
					else if (r < 80)
						pos_now = pos_now + {1'b0, gap_limit} - $urandom_range(2);
					else if (r < 90)
						pos_now = pos_now - $urandom_range(step_cap);
					else
						pos_now = $urandom;
					send_item(ACT_APPEND, seg_now, pos_now, $urandom);
				end
				n_queries = $urandom_range(1, 10);
				for (int q = 0; q < n_queries; q++) begin
					r = $urandom_range(99);
					if (n_anchors == 0 || r >= 92) begin
						idx = $urandom_range(8191);
					end else if (r < 75) begin
						idx = $urandom_range(n_anchors - 1);
					end else if (r < 85) begin
						tail_span = (n_anchors - 1 < 17) ? n_anchors - 1 : 17;
						idx = n_anchors - 1 - $urandom_range(tail_span);
					end else begin
						idx = n_anchors + $urandom_range(2);
					end
					send_item(ACT_QUERY, $urandom, $urandom, idx);
				end
			end
			// Now and then the sender holds off until every reply is back.
			if ($urandom_range(99) < 5)
				wait_until_idle();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_extremes();
		test_full_store();

		// Random phases: no idling, a mostly idle sender and a lightly idle sender, twice over,
		// each phase under its own gap limit.
		test_random_reads(RANDOM_ITEMS / 6, 0, gap_t'(GAP_RESET));
		test_random_reads(RANDOM_ITEMS / 6, 86, gap_t'($urandom_range(1, 300)));
		test_random_reads(RANDOM_ITEMS / 6, 18, '0);
		test_random_reads(RANDOM_ITEMS / 6, 0, GAP_MAX);
		test_random_reads(RANDOM_ITEMS / 6, 86, gap_t'($urandom));
		test_random_reads(RANDOM_ITEMS / 6, 18, gap_t'($urandom_range(2000, 60000)));

		wait_until_idle();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
hdl/asrc_pkg.sv
hdl/asrc_store.sv
hdl/asrc_query.sv
hdl/anchor_successor_range_counter_top.sv
hdl/asrc_chk.sv
tb/tb.sv
